// ===== rtl/bcs_pkg.sv =====
// Shared types, constants and bitset helpers for the clique search core.
// No dependencies; imported by every module of the block.
`default_nettype none

package bcs_pkg;

  // Field widths fixed by the interface
  localparam int DATA_W     = 64;
  localparam int IDX_W      = 6;
  localparam int K_W        = 4;
  localparam int CNT_W      = 7;
  localparam int AV_W       = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int LEVEL_W    = 4;

  // Defaults for the top-level parameters
  localparam int VERTICES_DEF   = 64;
  localparam int MAX_CLIQUE_DEF = 8;

  // Decoupling queue between front and engine
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPLEMENT = 1'd1;

  localparam logic [AV_W-1:0] ACTIVE_RESET = 7'd64;

  // Item classes handed from the front to the engine
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_TRUE  = 2'd2,
    KIND_FALSE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   idx;
    logic [DATA_W-1:0]  data;   // row bits for a write, masked candidates for a query
    logic [K_W-1:0]     k;
  } bcs_item_t;

  // Engine status seen by the top level
  typedef struct packed {
    logic               idle;
    logic               report;
    logic [LEVEL_W-1:0] level;
  } eng_stat_t;

  // Mask of bits 0..n-1
  function automatic logic [DATA_W-1:0] low_mask(input logic [AV_W-1:0] n);
    logic [DATA_W-1:0] m;
    for (int i = 0; i < DATA_W; i++) begin
      m[i] = (AV_W'(i) < n);
    end
    return m;
  endfunction

  function automatic logic [CNT_W-1:0] pop_count(input logic [DATA_W-1:0] x);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < DATA_W; i++) begin
      c = c + CNT_W'(x[i]);
    end
    return c;
  endfunction

  // Index of the lowest set bit, zero for an empty word
  function automatic logic [IDX_W-1:0] lowest_index(input logic [DATA_W-1:0] x);
    logic [IDX_W-1:0] v;
    v = '0;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      if (x[i]) begin
        v = IDX_W'(i);
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bcs_queue.sv =====
// Small in-order item queue between the front and the search engine.
// Depends on bcs_pkg for the item type and depth.
`default_nettype none

module bcs_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  bcs_pkg::bcs_item_t   push_item,
  output logic                 ready,
  output logic                 valid,
  output bcs_pkg::bcs_item_t   item,
  input  wire                  pop
);
  import bcs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  bcs_item_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;

  assign ready = (count_r != CNT_QW'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign item  = slot_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage slots, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bcs_front.sv =====
// Input front: accepts items, restricts query masks and sorts out trivial answers.
// Depends on bcs_pkg; feeds bcs_queue.
`default_nettype none

module bcs_front #(
  parameter int VERTICES   = bcs_pkg::VERTICES_DEF,
  parameter int MAX_CLIQUE = bcs_pkg::MAX_CLIQUE_DEF
) (
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_func,
  input  wire [bcs_pkg::IDX_W-1:0]     in_row_index,
  input  wire [bcs_pkg::DATA_W-1:0]    in_row_bits,
  input  wire [bcs_pkg::DATA_W-1:0]    in_candidate_mask,
  input  wire [bcs_pkg::K_W-1:0]       in_clique_size,
  input  wire [bcs_pkg::DATA_W-1:0]    act_mask,
  input  wire                          q_ready,
  output logic                         q_push,
  output bcs_pkg::bcs_item_t           q_item
);
  import bcs_pkg::*;

  logic row_in_range;

  assign in_ready     = q_ready;
  assign row_in_range = ({1'b0, in_row_index} < (IDX_W + 1)'(VERTICES));

  // Classify the item; writes to rows that do not exist are dropped here
  always_comb begin
    q_item.idx  = in_row_index;
    q_item.k    = in_clique_size;
    if (!in_func) begin
      q_item.kind = KIND_WRITE;
      q_item.data = in_row_bits;
    end else begin
      q_item.data = in_candidate_mask & act_mask;
      if (in_clique_size == '0) begin
        q_item.kind = KIND_TRUE;
      end else if ({1'b0, in_clique_size} > (K_W + 1)'(MAX_CLIQUE)) begin
        q_item.kind = KIND_FALSE;
      end else begin
        q_item.kind = KIND_QUERY;
      end
    end
  end

  assign q_push = in_valid && q_ready && (in_func || row_in_range);

endmodule

`default_nettype wire

// ===== rtl/bcs_engine.sv =====
// Back end: adjacency row memory and the depth-first clique search sequencer.
// Depends on bcs_pkg; takes items from bcs_queue and drives the result register.
`default_nettype none

module bcs_engine #(
  parameter int VERTICES   = bcs_pkg::VERTICES_DEF,
  parameter int MAX_CLIQUE = bcs_pkg::MAX_CLIQUE_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          q_valid,
  input  bcs_pkg::bcs_item_t           q_item,
  output logic                         q_pop,
  input  wire [bcs_pkg::DATA_W-1:0]    act_mask,
  input  wire                          complement,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_found,
  output bcs_pkg::eng_stat_t           stat
);
  import bcs_pkg::*;

  localparam int AW = $clog2(VERTICES);
  localparam int DW = (MAX_CLIQUE > 1) ? $clog2(MAX_CLIQUE) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EVAL   = 4'b0010,
    ST_EXPAND = 4'b0100,
    ST_REPORT = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [DATA_W-1:0] cur_r, cur_nxt;
  logic [DW-1:0]     d_r, d_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [IDX_W-1:0]  v_r, v_nxt;
  logic              found_r, found_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [DATA_W-1:0] lvl_r [MAX_CLIQUE];
  logic              lvl_we;

  logic [DATA_W-1:0] mem [VERTICES];
  logic [DATA_W-1:0] rd_data_r;
  logic              mem_we;

  logic [CNT_W-1:0]  cnt;
  logic [K_W-1:0]    need;
  logic [IDX_W-1:0]  low_v;
  logic [DATA_W-1:0] cur_cleared;
  logic [DATA_W-1:0] row_eff;

  // Per-node terms of the current candidate set
  assign cnt         = pop_count(cur_r);
  assign need        = k_r - K_W'(d_r);
  assign low_v       = lowest_index(cur_r);
  assign cur_cleared = cur_r & ~(DATA_W'(1) << low_v);

  // Adjacency row of the vertex just taken, complemented on request
  always_comb begin
    row_eff = rd_data_r;
    if (complement) begin
      row_eff = act_mask & ~(rd_data_r | (DATA_W'(1) << v_r));
    end
  end

  assign q_pop  = (state_r == ST_IDLE) && q_valid;
  assign mem_we = q_pop && (q_item.kind == KIND_WRITE);
  assign lvl_we = (state_r == ST_EVAL) && (cnt >= CNT_W'(need)) && (need != K_W'(1));

  // Search sequencer
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    d_nxt     = d_r;
    k_nxt     = k_r;
    v_nxt     = v_r;
    found_nxt = found_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.kind)
            KIND_TRUE: begin
              found_nxt = 1'b1;
              state_nxt = ST_REPORT;
            end
            KIND_FALSE: begin
              found_nxt = 1'b0;
              state_nxt = ST_REPORT;
            end
            KIND_QUERY: begin
              cur_nxt   = q_item.data;
              k_nxt     = q_item.k;
              d_nxt     = '0;
              state_nxt = ST_EVAL;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_EVAL: begin
        if (cnt < CNT_W'(need)) begin
          // too few candidates left: back up one level or give up
          if (d_r == '0) begin
            found_nxt = 1'b0;
            state_nxt = ST_REPORT;
          end else begin
            d_nxt   = d_r - 1'b1;
            cur_nxt = lvl_r[d_r - 1'b1];
          end
        end else if (need == K_W'(1)) begin
          found_nxt = 1'b1;
          state_nxt = ST_REPORT;
        end else begin
          // take the lowest vertex; its row arrives from memory next cycle
          cur_nxt   = cur_cleared;
          v_nxt     = low_v;
          state_nxt = ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        cur_nxt   = cur_r & row_eff;
        d_nxt     = d_r + 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_REPORT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == ST_REPORT) && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      d_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      d_r         <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    k_r         <= k_nxt;
    v_r         <= v_nxt;
    found_r     <= found_nxt;
    out_found_r <= out_found_nxt;
  end

  // Stack of remaining candidates per level
  always_ff @(posedge clk) begin
    if (lvl_we) begin
      lvl_r[d_r] <= cur_cleared;
    end
  end

  // Adjacency memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_item.idx[AW-1:0]] <= q_item.data;
    end
    rd_data_r <= mem[low_v[AW-1:0]];
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign stat.idle    = (state_r == ST_IDLE);
  assign stat.report  = (state_r == ST_REPORT);
  assign stat.level   = LEVEL_W'(d_r);

endmodule

`default_nettype wire

// ===== rtl/bitset_clique_search_core.sv =====
// Top level of the clique search core: configuration registers, front, queue, engine.
// Depends on bcs_pkg, bcs_front, bcs_queue and bcs_engine.
`default_nettype none

// The core keeps one 64-bit adjacency row per vertex and answers whether a
// clique of clique_size vertices lies within a candidate mask. A row write
// (func 0) is stored as the engine takes it and returns nothing; writes to
// rows at or above VERTICES are dropped. A query (func 1) returns exactly one
// found bit. Sizes of zero, or above MAX_CLIQUE, go straight to the report
// step. Other queries run a depth-first search on a single sequencer that
// takes the item, expands each node (count and pick, then the registered
// adjacency memory read and intersect), backs up when too few candidates
// remain and posts the result; the node count depends on the graph and is
// exponential in the worst case. Items queue two deep ahead of the engine,
// so up to two items are still accepted while a search runs or a result
// waits at the output. Setting search_complement searches the complement
// graph over the active vertices. The user must write configuration only
// while idle; the block itself does not enforce it.
module bitset_clique_search_core #(
  parameter int VERTICES   = bcs_pkg::VERTICES_DEF,
  parameter int MAX_CLIQUE = bcs_pkg::MAX_CLIQUE_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [bcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [bcs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              in_func,
  input  wire [bcs_pkg::IDX_W-1:0]         in_row_index,
  input  wire [bcs_pkg::DATA_W-1:0]        in_row_bits,
  input  wire [bcs_pkg::DATA_W-1:0]        in_candidate_mask,
  input  wire [bcs_pkg::K_W-1:0]           in_clique_size,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_found
);
  import bcs_pkg::*;

  logic [AV_W-1:0]   active_r;
  logic              compl_r;
  logic [AV_W-1:0]   active_sat;
  logic [DATA_W-1:0] act_mask;

  logic              q_push, q_ready, q_valid, q_pop;
  bcs_item_t         push_item, q_item;
  eng_stat_t         stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
      compl_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE:     active_r <= cfg_wdata;
        REG_COMPLEMENT: compl_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Active vertex mask, count saturated at the stored row count
  assign active_sat = (active_r > AV_W'(VERTICES)) ? AV_W'(VERTICES) : active_r;
  assign act_mask   = low_mask(active_sat);

  bcs_front #(
    .VERTICES   (VERTICES),
    .MAX_CLIQUE (MAX_CLIQUE)
  ) u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_row_index      (in_row_index),
    .in_row_bits       (in_row_bits),
    .in_candidate_mask (in_candidate_mask),
    .in_clique_size    (in_clique_size),
    .act_mask          (act_mask),
    .q_ready           (q_ready),
    .q_push            (q_push),
    .q_item            (push_item)
  );

  bcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .ready     (q_ready),
    .valid     (q_valid),
    .item      (q_item),
    .pop       (q_pop)
  );

  bcs_engine #(
    .VERTICES   (VERTICES),
    .MAX_CLIQUE (MAX_CLIQUE)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .act_mask   (act_mask),
    .complement (compl_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_found  (out_found),
    .stat       (stat)
  );

  // The engine takes a new item only between searches
  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> stat.idle)
    else $error("queue popped while the engine was busy");

  // The search stack never goes past its last level
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.level <= LEVEL_W'(MAX_CLIQUE - 1))
    else $error("search level beyond stack depth");

  // A fresh result only ever comes from the report step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(stat.report))
    else $error("result posted outside the report step");

  // Leaving the report step means the result register took the item
  a_report_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.report && (!out_valid || out_ready)) |=> (out_valid && stat.idle))
    else $error("report step left without posting the item");

endmodule

`default_nettype wire

// ===== verif/bitset_clique_search_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the bitset clique search core: row loads, clique queries,
// both search modes, idling and back-pressure phases. Depends on bcs_pkg and the core RTL.
module bitset_clique_search_core_tb;
  import bcs_pkg::*;

  localparam int VERTICES      = VERTICES_DEF;
  localparam int MAX_CLIQUE    = MAX_CLIQUE_DEF;
  localparam int SETTLE_CYCLES = 16;     // queue plus engine, with margin
  localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
  localparam int LIGHT_STEPS   = 500;    // search steps allowed for an ordinary query
  localparam int HEAVY_STEPS   = 60000;  // search steps allowed for a wide query

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_func;
  logic [IDX_W-1:0]      in_row_index;
  logic [DATA_W-1:0]     in_row_bits;
  logic [DATA_W-1:0]     in_candidate_mask;
  logic [K_W-1:0]        in_clique_size;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_found;

  // Predictor state: graph rows and register copies
  logic [DATA_W-1:0] graph_rows [VERTICES];
  logic [AV_W-1:0]   model_active;
  logic              model_complement;

  logic pending_found [$];   // expected found bits, oldest first
  logic want_found;

  int     send_idle_pct;
  int     recv_stall_pct;
  int     mismatches = 0;
  int     hold_requests = 0;
  int     hold_served = 0;
  int     hold_left = 0;
  longint cycle_count = 0;
  longint cycle_budget = 20000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  bitset_clique_search_core #(
    .VERTICES   (VERTICES),
    .MAX_CLIQUE (MAX_CLIQUE)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_row_index      (in_row_index),
    .in_row_bits       (in_row_bits),
    .in_candidate_mask (in_candidate_mask),
    .in_clique_size    (in_clique_size),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found)
  );

  // Long hold-off, counted here so the receiver only sees a flag
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
    end
  end

  // Receiver: random stalls plus the hold-off
  always @(posedge clk) begin
    out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_found.size() == 0) begin
        report_mismatch("result with no query waiting", 1'bx, out_found);
      end else begin
        want_found = pending_found.pop_front();
        if (out_found !== want_found) begin
          report_mismatch("found", want_found, out_found);
        end
      end
    end
  end

  // Watchdog: the budget grows with the work handed to the block
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_budget) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic want, input logic got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t: %s expected %b got %b", $time, what, want, got);
    end
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [DATA_W-1:0] first_bits(input int n);
    if (n >= DATA_W) return '1;
    if (n <= 0) return '0;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic logic [DATA_W-1:0] active_set();
    int n;
    n = int'(model_active);
    if (n > VERTICES) n = VERTICES;
    return first_bits(n);
  endfunction

  // Row as the search sees it; complement mode flips it within the active set
  function automatic logic [DATA_W-1:0] neighbors(input int v);
    logic [DATA_W-1:0] r;
    r = graph_rows[v];
    if (model_complement) r = active_set() & ~(r | (64'd1 << v));
    return r;
  endfunction

  // Depth-first search, lowest vertex first, pruned on population count.
  // steps counts visited nodes and backtracks, used for the cycle budget.
  function automatic logic clique_exists(input logic [DATA_W-1:0] mask,
                                         input logic [K_W-1:0] k, output int steps);
    logic [DATA_W-1:0] level [MAX_CLIQUE];
    int   d;
    int   need;
    int   v;
    logic found;
    logic done;
    steps = 0;
    if (k == 0) return 1'b1;
    if (k > MAX_CLIQUE) return 1'b0;
    foreach (level[i]) level[i] = '0;
    level[0] = mask & active_set() & first_bits(VERTICES);
    d     = 0;
    found = 1'b0;
    done  = 1'b0;
    while (!done) begin
      steps++;
      need = int'(k) - d;
      if ($countones(level[d]) < need) begin
        if (d == 0) done = 1'b1;
        else d--;
      end else begin
        v = 0;
        while (!level[d][v]) v++;
        level[d][v] = 1'b0;
        if (need == 1) begin
          found = 1'b1;
          done  = 1'b1;
        end else begin
          level[d+1] = level[d] & neighbors(v);
          d++;
        end
      end
    end
    return found;
  endfunction

  // Offer one item; valid stays up between back-to-back items
  task automatic send_item(input logic func, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] bits, input logic [DATA_W-1:0] mask,
                           input logic [K_W-1:0] k);
    int   steps;
    logic predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= func;
    in_row_index      <= idx;
    in_row_bits       <= bits;
    in_candidate_mask <= mask;
    in_clique_size    <= k;
    do @(posedge clk); while (!in_ready);
    if (func == FUNC_WRITE) begin
      if (int'(idx) < VERTICES) graph_rows[idx] = bits;
      cycle_budget += 400;
    end else begin
      predicted     = clique_exists(mask, k, steps);
      pending_found = {pending_found, predicted};
      cycle_budget += 400 + 8 * steps;
    end
  endtask

  // Sender pauses until every result is back, then lets trailing writes finish
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_found.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cycle_budget += 4 * SETTLE_CYCLES;
  endtask

  // Both registers, back to back, only with the block idle
  task automatic configure(input int active, input logic compl);
    logic [CFG_DATA_W-1:0] wdata;
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ACTIVE;
    cfg_wdata <= CFG_DATA_W'(active);
    @(posedge clk);
    model_active = AV_W'(active);
    wdata        = CFG_DATA_W'($urandom);
    wdata[0]     = compl;   // upper bits are don't-care
    cfg_index <= REG_COMPLEMENT;
    cfg_wdata <= wdata;
    @(posedge clk);
    model_complement = compl;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random query; the mask is thinned until the search fits the step cap
  task automatic random_query(input int cap, input logic wide);
    logic [DATA_W-1:0] mask;
    logic [K_W-1:0]    k;
    int                steps;
    case ($urandom_range(3))
      0:       mask = rand_word() & rand_word() & rand_word();
      1:       mask = rand_word() & rand_word();
      2:       mask = rand_word();
      default: mask = rand_word() & first_bits($urandom_range(24, 1));
    endcase
    if ($urandom_range(99) < 8) k = K_W'($urandom_range(15, MAX_CLIQUE + 1));
    else k = K_W'($urandom_range(MAX_CLIQUE));
    if (wide) begin
      mask = '1;
      k    = K_W'($urandom_range(MAX_CLIQUE, 5));
    end
    void'(clique_exists(mask, k, steps));
    while (steps > cap) begin
      mask &= rand_word();
      void'(clique_exists(mask, k, steps));
    end
    send_item(FUNC_QUERY, IDX_W'($urandom), rand_word(), mask, k);
  endtask

  task automatic random_row_write();
    logic [DATA_W-1:0] row;
    case ($urandom_range(3))
      0:       row = rand_word() | rand_word();
      1:       row = rand_word() & rand_word();
      default: row = rand_word();
    endcase
    send_item(FUNC_WRITE, IDX_W'($urandom_range(VERTICES - 1)), row, rand_word(),
              K_W'($urandom));
  endtask

  // Every row gets written before any query can read it
  task automatic test_graph_load();
    for (int v = 0; v < VERTICES; v++) begin
      send_item(FUNC_WRITE, IDX_W'(v), rand_word(), rand_word(), K_W'($urandom));
    end
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(64, 1'b0);
    send_item(FUNC_WRITE, '0, '1, '0, '0);
    send_item(FUNC_WRITE, '1, '0, '1, '1);
    // size zero is always found, even on an empty mask
    send_item(FUNC_QUERY, '0, '0, '1, 4'd0);
    send_item(FUNC_QUERY, '1, '1, '0, 4'd0);
    send_item(FUNC_QUERY, '0, '0, '0, 4'd1);
    send_item(FUNC_QUERY, '0, '0, '1, 4'd1);
    // sizes beyond the stack depth
    send_item(FUNC_QUERY, '0, '0, '1, 4'd9);
    send_item(FUNC_QUERY, '0, '0, '1, 4'd15);
    send_item(FUNC_QUERY, '0, '0, 64'h3, 4'd2);
    send_item(FUNC_QUERY, '0, '0, 64'h8000_0000_0000_0001, 4'd2);
    send_item(FUNC_QUERY, '0, '0, 64'hC000_0000_0000_0000, 4'd2);
    send_item(FUNC_QUERY, '0, '0, '1, K_W'(MAX_CLIQUE));
    // complement graph: triangle check and a full row turned empty
    configure(64, 1'b1);
    send_item(FUNC_QUERY, '0, '0, '1, 4'd3);
    send_item(FUNC_QUERY, '0, '0, 64'h3, 4'd2);
    // no active vertices
    configure(0, 1'b0);
    send_item(FUNC_QUERY, '0, '0, '1, 4'd1);
    send_item(FUNC_QUERY, '0, '0, '1, 4'd0);
    // single active vertex
    configure(1, 1'b1);
    send_item(FUNC_QUERY, '0, '0, '1, 4'd1);
    send_item(FUNC_QUERY, '0, '0, '1, 4'd2);
    // counts above the vertex count saturate
    configure(127, 1'b0);
    send_item(FUNC_QUERY, '0, '0, 64'h8000_0000_0000_0000, 4'd1);
    configure(65, 1'b1);
    send_item(FUNC_QUERY, '0, '0, '1, 4'd2);
  endtask

  function automatic int pick_active();
    case ($urandom_range(9))
      0:       return 0;
      1:       return $urandom_range(127, 65);
      2, 3:    return 64;
      default: return $urandom_range(64, 1);
    endcase
  endfunction

  // Mixed writes and queries under one idling profile, two register settings
  task automatic test_random_phase(input int n_items, input int send_pct,
                                   input int stall_pct, input logic with_wide);
    for (int i = 0; i < n_items; i++) begin
      if (i == 0 || i == n_items / 2) begin
        configure(pick_active(), 1'($urandom_range(1)));
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
      end
      if ($urandom_range(99) < 15) random_row_write();
      else if (with_wide && i == n_items / 4) random_query(HEAVY_STEPS, 1'b1);
      else random_query(LIGHT_STEPS, 1'b0);
    end
  endtask

  // Receiver holds off while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests <= hold_requests + 1;
    cycle_budget  += 4 * HOLD_CYCLES;
    for (int i = 0; i < 20; i++) random_query(LIGHT_STEPS / 5, 1'b0);
    drain();
    for (int i = 0; i < 10; i++) random_query(LIGHT_STEPS, 1'b0);
    drain();
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    in_valid          <= 1'b0;
    in_func           <= FUNC_WRITE;
    in_row_index      <= '0;
    in_row_bits       <= '0;
    in_candidate_mask <= '0;
    in_clique_size    <= '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    model_active      = ACTIVE_RESET;
    model_complement  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_graph_load();
    test_directed();
    test_random_phase(110, 0, 0, 1'b1);
    test_random_phase(110, 55, 0, 1'b0);
    test_random_phase(110, 0, 55, 1'b1);
    test_random_phase(110, 37, 37, 1'b0);
    test_backpressure();
    drain();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
